### sv/fsp_pkg.sv
`timescale 1ns / 1ps
package fsp_pkg;

  localparam int NumWidth = 32;
  localparam int MagW     = NumWidth - 1;
  localparam int CntW     = $clog2(MagW + 1);

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharPlus  = 8'h2B;

  typedef logic [4:0] fsp_cmd_t;

  localparam fsp_cmd_t CMD_NOP      = 5'd0;
  localparam fsp_cmd_t CMD_LATCH    = 5'd1;
  localparam fsp_cmd_t CMD_APPLY    = 5'd2;
  localparam fsp_cmd_t CMD_ABORT    = 5'd3;
  localparam fsp_cmd_t CMD_GCD_LD_F = 5'd4;
  localparam fsp_cmd_t CMD_GCD_LD_R = 5'd5;
  localparam fsp_cmd_t CMD_GCD_STEP = 5'd6;
  localparam fsp_cmd_t CMD_DIV_LD_A = 5'd7;
  localparam fsp_cmd_t CMD_DIV_LD_C = 5'd8;
  localparam fsp_cmd_t CMD_DIV_LD_M = 5'd9;
  localparam fsp_cmd_t CMD_DIV_STEP = 5'd10;
  localparam fsp_cmd_t CMD_Q_SAVE   = 5'd11;
  localparam fsp_cmd_t CMD_MUL_L    = 5'd12;
  localparam fsp_cmd_t CMD_MUL_T1   = 5'd13;
  localparam fsp_cmd_t CMD_MUL_T2   = 5'd14;
  localparam fsp_cmd_t CMD_ADD      = 5'd15;
  localparam fsp_cmd_t CMD_OUT      = 5'd16;

  typedef struct packed {
    logic last;
    logic den_end;
    logic den_zero;
    logic err;
    logic gcd_done;
    logic div_done;
    logic out_busy;
  } fsp_status_t;

endpackage

### sv/fsp_datapath.sv
`timescale 1ns / 1ps
module fsp_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  fsp_pkg::fsp_cmd_t            cmd,
  output fsp_pkg::fsp_status_t         status,
  input  logic [7:0]                   char_code,
  input  logic                         last_char,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [31:0]           sum_numerator,
  output logic [30:0]                  sum_denominator,
  output logic                         error_flag
);
  import fsp_pkg::*;

  localparam logic [1:0] PhaseStart = 2'd0;
  localparam logic [1:0] PhaseNum   = 2'd1;
  localparam logic [1:0] PhaseDen   = 2'd2;

  logic [7:0]        ch;
  logic              last_q;
  logic              acc_neg;
  logic [MagW-1:0]   acc_mag;
  logic [MagW-1:0]   acc_den;
  logic [MagW-1:0]   cur_num;
  logic [MagW-1:0]   cur_den;
  logic              cur_neg;
  logic [1:0]        phase;
  logic              err;

  logic [MagW-1:0]   ga, gb, g;
  logic [CntW-1:0]   gk;
  logic [MagW-1:0]   dr, dq, dg, qa;
  logic [CntW-1:0]   dcnt;
  logic [MagW-1:0]   l_val, t1;
  logic [2*MagW-1:0] prod;
  logic [MagW-1:0]   mul_a, mul_b;

  logic              dig;
  logic [3:0]        dval;
  logic              gcd_done;
  logic [MagW:0]     div_t;
  logic              prod_ovf;
  logic [MagW:0]     sum_s;
  logic              same_sign;

  function automatic logic [MagW+3:0] dig_ext(input logic [MagW-1:0] v, input logic [3:0] d);
    dig_ext = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {{MagW{1'b0}}, d};
  endfunction

  logic [MagW+3:0] num_ext, den_ext;

  assign dig      = (ch >= CharZero) && (ch <= CharNine);
  assign dval     = dig ? 4'(ch - CharZero) : 4'd0;
  assign num_ext  = dig_ext(cur_num, dval);
  assign den_ext  = dig_ext(cur_den, dval);
  assign gcd_done = (ga == '0) || (gb == '0);
  assign div_t    = {dr, dq[MagW-1]};
  assign prod_ovf = |prod[2*MagW-1:MagW];
  assign same_sign = (acc_neg == cur_neg);
  assign sum_s    = {1'b0, t1} + {1'b0, prod[MagW-1:0]};

  always_comb begin
    unique case (cmd)
      CMD_MUL_L: begin
        mul_a = qa;
        mul_b = cur_den;
      end
      CMD_MUL_T1: begin
        mul_a = acc_mag;
        mul_b = dq;
      end
      default: begin
        mul_a = cur_num;
        mul_b = qa;
      end
    endcase
  end

  assign status.last     = last_q;
  assign status.den_end  = (phase == PhaseDen) && !dig;
  assign status.den_zero = (cur_den == '0);
  assign status.err      = err;
  assign status.gcd_done = gcd_done;
  assign status.div_done = (dcnt == '0);
  assign status.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_neg   <= 1'b0;
      acc_mag   <= '0;
      acc_den   <= MagW'(1);
      cur_num   <= '0;
      cur_den   <= '0;
      cur_neg   <= 1'b0;
      phase     <= PhaseStart;
      err       <= 1'b0;
      dcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && cmd != CMD_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (cmd)
        CMD_LATCH: begin
          ch     <= char_code;
          last_q <= last_char;
        end
        CMD_APPLY: begin
          if (phase == PhaseDen) begin
            if (|den_ext[MagW+3:MagW]) begin
              err     <= 1'b1;
              cur_den <= '0;
            end else begin
              cur_den <= den_ext[MagW-1:0];
            end
          end else if (phase != PhaseNum && (ch == CharMinus || ch == CharPlus)) begin
            phase   <= PhaseNum;
            cur_neg <= (ch == CharMinus);
          end else if (dig) begin
            phase <= PhaseNum;
            if (|num_ext[MagW+3:MagW]) begin
              err     <= 1'b1;
              cur_num <= '0;
            end else begin
              cur_num <= num_ext[MagW-1:0];
            end
          end else begin
            phase <= PhaseDen;
          end
        end
        CMD_ABORT: begin
          if (cur_den == '0) begin
            err <= 1'b1;
          end
          cur_num <= '0;
          cur_den <= '0;
          cur_neg <= 1'b0;
          phase   <= PhaseStart;
        end
        CMD_GCD_LD_F: begin
          ga <= acc_den;
          gb <= cur_den;
          gk <= '0;
        end
        CMD_GCD_LD_R: begin
          ga <= acc_mag;
          gb <= acc_den;
          gk <= '0;
        end
        CMD_GCD_STEP: begin
          if (gcd_done) begin
            g <= (ga | gb) << gk;
          end else if (!ga[0] && !gb[0]) begin
            ga <= ga >> 1;
            gb <= gb >> 1;
            gk <= gk + CntW'(1);
          end else if (!ga[0]) begin
            ga <= ga >> 1;
          end else if (!gb[0]) begin
            gb <= gb >> 1;
          end else if (ga >= gb) begin
            ga <= ga - gb;
          end else begin
            gb <= gb - ga;
          end
        end
        CMD_DIV_LD_A, CMD_DIV_LD_C, CMD_DIV_LD_M: begin
          dr   <= '0;
          dg   <= g;
          dcnt <= CntW'(MagW);
          if (cmd == CMD_DIV_LD_A) begin
            dq <= acc_den;
          end else if (cmd == CMD_DIV_LD_C) begin
            dq <= cur_den;
          end else begin
            dq <= acc_mag;
          end
        end
        CMD_DIV_STEP: begin
          if (dcnt != '0) begin
            dcnt <= dcnt - CntW'(1);
            if (div_t >= {1'b0, dg}) begin
              dr <= MagW'(div_t - {1'b0, dg});
              dq <= {dq[MagW-2:0], 1'b1};
            end else begin
              dr <= div_t[MagW-1:0];
              dq <= {dq[MagW-2:0], 1'b0};
            end
          end
        end
        CMD_Q_SAVE: begin
          qa <= dq;
        end
        CMD_MUL_L: begin
          prod <= mul_a * mul_b;
        end
        CMD_MUL_T1: begin
          l_val <= prod[MagW-1:0];
          if (prod_ovf) begin
            err <= 1'b1;
          end
          prod <= mul_a * mul_b;
        end
        CMD_MUL_T2: begin
          t1 <= prod[MagW-1:0];
          if (prod_ovf) begin
            err <= 1'b1;
          end
          prod <= mul_a * mul_b;
        end
        CMD_ADD: begin
          // The product register holds the scaled current numerator here.
          if (prod_ovf || (same_sign && sum_s[MagW])) begin
            err <= 1'b1;
          end else if (!err) begin
            acc_den <= l_val;
            if (same_sign) begin
              acc_mag <= sum_s[MagW-1:0];
              acc_neg <= acc_neg && (sum_s[MagW-1:0] != '0);
            end else if (t1 >= prod[MagW-1:0]) begin
              acc_mag <= t1 - prod[MagW-1:0];
              acc_neg <= acc_neg && (t1 != prod[MagW-1:0]);
            end else begin
              acc_mag <= prod[MagW-1:0] - t1;
              acc_neg <= cur_neg;
            end
          end
          cur_num <= '0;
          cur_den <= '0;
          cur_neg <= 1'b0;
          phase   <= PhaseStart;
        end
        CMD_OUT: begin
          out_valid <= 1'b1;
          if (err) begin
            sum_numerator   <= '0;
            sum_denominator <= 31'd1;
            error_flag      <= 1'b1;
          end else begin
            sum_numerator   <= acc_neg ? -$signed({1'b0, qa}) : $signed({1'b0, qa});
            sum_denominator <= dq;
            error_flag      <= 1'b0;
          end
          acc_neg <= 1'b0;
          acc_mag <= '0;
          acc_den <= MagW'(1);
          cur_num <= '0;
          cur_den <= '0;
          cur_neg <= 1'b0;
          phase   <= PhaseStart;
          err     <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  a_rise_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd == CMD_OUT))
    else $error("result appeared without an output command");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_DIV_STEP && dcnt != '0) |-> (dg != '0))
    else $error("divider running with a zero divisor");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    acc_den != '0)
    else $error("running denominator became zero");

endmodule

### sv/fsp_ctrl.sv
`timescale 1ns / 1ps
module fsp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fsp_pkg::fsp_status_t status,
  output fsp_pkg::fsp_cmd_t    cmd
);
  import fsp_pkg::*;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DECODE  = 5'd1;
  localparam logic [4:0] S_APPLY   = 5'd2;
  localparam logic [4:0] S_FSTART  = 5'd3;
  localparam logic [4:0] S_FGCD    = 5'd4;
  localparam logic [4:0] S_FDIVA_L = 5'd5;
  localparam logic [4:0] S_FDIVA   = 5'd6;
  localparam logic [4:0] S_FDIVC_L = 5'd7;
  localparam logic [4:0] S_FDIVC   = 5'd8;
  localparam logic [4:0] S_MUL_T1  = 5'd9;
  localparam logic [4:0] S_MUL_T2  = 5'd10;
  localparam logic [4:0] S_ADD     = 5'd11;
  localparam logic [4:0] S_RSTART  = 5'd12;
  localparam logic [4:0] S_RGCD    = 5'd13;
  localparam logic [4:0] S_RDIVM_L = 5'd14;
  localparam logic [4:0] S_RDIVM   = 5'd15;
  localparam logic [4:0] S_RDIVA_L = 5'd16;
  localparam logic [4:0] S_RDIVA   = 5'd17;
  localparam logic [4:0] S_OUT     = 5'd18;

  logic [4:0] state, state_next;
  logic       fin_last, fin_last_next;
  logic [4:0] ret_state;

  assign in_ready  = (state == S_IDLE);
  assign ret_state = fin_last ? S_RSTART : S_APPLY;

  always_comb begin
    state_next    = state;
    fin_last_next = fin_last;
    cmd           = CMD_NOP;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd        = CMD_LATCH;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status.den_end) begin
          fin_last_next = 1'b0;
          state_next    = S_FSTART;
        end else begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd = CMD_APPLY;
        if (status.last) begin
          fin_last_next = 1'b1;
          state_next    = S_FSTART;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_FSTART: begin
        if (status.den_zero || status.err) begin
          cmd        = CMD_ABORT;
          state_next = ret_state;
        end else begin
          cmd        = CMD_GCD_LD_F;
          state_next = S_FGCD;
        end
      end
      S_FGCD: begin
        cmd = CMD_GCD_STEP;
        if (status.gcd_done) begin
          state_next = S_FDIVA_L;
        end
      end
      S_FDIVA_L: begin
        cmd        = CMD_DIV_LD_A;
        state_next = S_FDIVA;
      end
      S_FDIVA: begin
        if (status.div_done) begin
          cmd        = CMD_Q_SAVE;
          state_next = S_FDIVC_L;
        end else begin
          cmd = CMD_DIV_STEP;
        end
      end
      S_FDIVC_L: begin
        cmd        = CMD_DIV_LD_C;
        state_next = S_FDIVC;
      end
      S_FDIVC: begin
        if (status.div_done) begin
          cmd        = CMD_MUL_L;
          state_next = S_MUL_T1;
        end else begin
          cmd = CMD_DIV_STEP;
        end
      end
      S_MUL_T1: begin
        cmd        = CMD_MUL_T1;
        state_next = S_MUL_T2;
      end
      S_MUL_T2: begin
        cmd        = CMD_MUL_T2;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd        = CMD_ADD;
        state_next = ret_state;
      end
      S_RSTART: begin
        if (status.err) begin
          state_next = S_OUT;
        end else begin
          cmd        = CMD_GCD_LD_R;
          state_next = S_RGCD;
        end
      end
      S_RGCD: begin
        cmd = CMD_GCD_STEP;
        if (status.gcd_done) begin
          state_next = S_RDIVM_L;
        end
      end
      S_RDIVM_L: begin
        cmd        = CMD_DIV_LD_M;
        state_next = S_RDIVM;
      end
      S_RDIVM: begin
        if (status.div_done) begin
          cmd        = CMD_Q_SAVE;
          state_next = S_RDIVA_L;
        end else begin
          cmd = CMD_DIV_STEP;
        end
      end
      S_RDIVA_L: begin
        cmd        = CMD_DIV_LD_A;
        state_next = S_RDIVA;
      end
      S_RDIVA: begin
        if (status.div_done) begin
          state_next = S_OUT;
        end else begin
          cmd = CMD_DIV_STEP;
        end
      end
      S_OUT: begin
        if (!status.out_busy) begin
          cmd        = CMD_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fin_last <= 1'b0;
    end else begin
      state    <= state_next;
      fin_last <= fin_last_next;
    end
  end

  a_out_not_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_OUT) |-> !status.out_busy)
    else $error("result written over one not yet taken");

  a_latch_then_decode: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_LATCH) |=> (state == S_DECODE))
    else $error("latched character not decoded");

endmodule

### sv/fraction_sum_parser_unit.sv
`timescale 1ns / 1ps
// Channel | Handshake           | Beat payload
// input   | in_valid / in_ready | char_code[7:0], last_char
// output  | out_valid/out_ready | sum_numerator[31:0] signed, sum_denominator[30:0], error_flag
//
// A character that does not close a fraction passes through latch, decode and update.
// Closing a fraction adds a binary gcd and two 31-step
// restoring divisions plus three multiplies, all in the one shared datapath.
// Unless an error is flagged, the last beat also runs one more gcd and two divisions to reduce the sum.
// Reset (rst, synchronous) returns the sum to 0/1 and the parser to its start.
// A waiting result stalls the block only when the next result is ready to go out.
module fraction_sum_parser_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         char_code,
  input  logic               last_char,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] sum_numerator,
  output logic [30:0]        sum_denominator,
  output logic               error_flag
);
  import fsp_pkg::*;

  fsp_cmd_t    cmd;
  fsp_status_t status;

  fsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  fsp_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .char_code       (char_code),
    .last_char       (last_char),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .sum_numerator   (sum_numerator),
    .sum_denominator (sum_denominator),
    .error_flag      (error_flag)
  );

endmodule
